[src/cll_pkg.sv]
// shared types and codes of the circular linked list manager
`default_nettype none

package cll_pkg;

  // fixed widths of the stream fields
  localparam int unsigned NODE_W   = 8;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 4'd8;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

  // link memory read address source
  typedef enum logic [1:0] {
    RD_POS,
    RD_CURSOR,
    RD_PREV
  } rd_sel_e;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SIMPLE,
    OP_SELF,
    OP_DROP_LAST,
    OP_SET_VICTIM,
    OP_TAKE_VICTIM,
    OP_LINK_W1,
    OP_LINK_W2,
    OP_UNLINK
  } dp_op_e;

  typedef struct packed {
    logic    load;
    rd_sel_e rd_sel;
    dp_op_e  op;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             count_one;
    logic             out_free;
  } stat_t;

  // input word layout, first field in the high bits
  typedef struct packed {
    logic [NODE_W-1:0] new_node;
    logic [NODE_W-1:0] position_node;
  } in_t;

  // output word layout, first field in the high bits
  typedef struct packed {
    logic [3:0]          pad;
    logic [NODE_W-1:0]   cursor_node;
    logic                list_empty;
    logic [SIZE_W-1:0]   list_size;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   popped_node;
  } res_t;

endpackage

`default_nettype wire

[src/cll_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module cll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[src/cll_datapath.sv]
// datapath: link memories, cursor, size count and result register
`default_nettype none

module cll_datapath #(
  parameter int unsigned NODE_COUNT = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [cll_pkg::IN_W-1:0]     in_data_i,
  input  wire logic [cll_pkg::CMD_W-1:0]    in_user_i,
  input  wire cll_pkg::ctl_t                ctl_i,
  output cll_pkg::stat_t                    stat_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [cll_pkg::OUT_W-1:0]    out_data_o,
  output logic                              out_user_o
);

  localparam int unsigned NW  = $clog2(NODE_COUNT);
  localparam int unsigned CW  = $clog2(NODE_COUNT + 1);
  localparam int unsigned TBL = 2 ** cll_pkg::NODE_W;

  // node index reduction, a constant table
  logic [NW-1:0] mod_tbl [TBL];
  for (genvar g = 0; g < TBL; g++) begin : g_mod
    assign mod_tbl[g] = NW'(g % NODE_COUNT);
  end

  cll_pkg::in_t in_word;
  assign in_word = cll_pkg::in_t'(in_data_i);

  logic [cll_pkg::CMD_W-1:0] cmd_q;
  logic [NW-1:0]             pos_q, fresh_q, victim_q, victim_d, link_q, link_d;
  logic [NW-1:0]             cursor_q, cursor_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      out_valid_q;
  cll_pkg::res_t             res_q, res_d;
  logic                      pvalid_q;

  logic          nxt_we, prv_we;
  logic [NW-1:0] nxt_waddr, prv_waddr, nxt_wdata, prv_wdata;
  logic [NW-1:0] raddr, nxt_rd, prv_rd;

  cll_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (raddr),
    .rdata_o (nxt_rd)
  );

  cll_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (raddr),
    .rdata_o (prv_rd)
  );

  always_comb begin
    unique case (ctl_i.rd_sel)
      cll_pkg::RD_POS:    raddr = pos_q;
      cll_pkg::RD_CURSOR: raddr = cursor_q;
      cll_pkg::RD_PREV:   raddr = prv_rd;
      default:            raddr = pos_q;
    endcase
  end

  logic          is_after, is_insert, finish, pvalid;
  logic [NW-1:0] anchor, link_rd, popped;
  logic [cll_pkg::STATUS_W-1:0] status;

  assign is_after  = (cmd_q == cll_pkg::CMD_INS_AFTER);
  assign is_insert = is_after || (cmd_q == cll_pkg::CMD_INS_BEFORE);
  // pushes link in before the cursor
  assign anchor    = is_insert ? pos_q : cursor_q;
  assign link_rd   = is_after ? nxt_rd : prv_rd;

  always_comb begin
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    nxt_waddr = fresh_q;
    prv_waddr = fresh_q;
    nxt_wdata = fresh_q;
    prv_wdata = fresh_q;
    cursor_d  = cursor_q;
    count_d   = count_q;
    victim_d  = victim_q;
    link_d    = link_q;
    finish    = 1'b0;
    pvalid    = 1'b0;
    popped    = '0;
    status    = cll_pkg::ST_OK;
    unique case (ctl_i.op)
      cll_pkg::OP_NONE: ;
      cll_pkg::OP_SIMPLE: begin
        finish = 1'b1;
        case (cmd_q) inside
          cll_pkg::CMD_CLEAR: begin
            count_d  = '0;
            cursor_d = '0;
          end
          cll_pkg::CMD_SET_CURSOR: cursor_d = pos_q;
          cll_pkg::CMD_INS_BEFORE, cll_pkg::CMD_INS_AFTER, cll_pkg::CMD_REMOVE:
            status = cll_pkg::ST_INVALID;
          cll_pkg::CMD_POP_FRONT, cll_pkg::CMD_POP_BACK:
            status = cll_pkg::ST_POP_EMPTY;
          default: ;
        endcase
      end
      cll_pkg::OP_SELF: begin
        // first node points at itself both ways
        nxt_we   = 1'b1;
        prv_we   = 1'b1;
        cursor_d = fresh_q;
        count_d  = CW'(1);
        finish   = 1'b1;
      end
      cll_pkg::OP_DROP_LAST: begin
        cursor_d = '0;
        count_d  = count_q - CW'(1);
        finish   = 1'b1;
        if (cmd_q == cll_pkg::CMD_POP_FRONT) begin
          pvalid = 1'b1;
          popped = cursor_q;
        end else if (cmd_q == cll_pkg::CMD_POP_BACK) begin
          pvalid = 1'b1;
          popped = prv_rd;
        end
      end
      cll_pkg::OP_SET_VICTIM: begin
        victim_d = (cmd_q == cll_pkg::CMD_REMOVE) ? pos_q : cursor_q;
      end
      cll_pkg::OP_TAKE_VICTIM: victim_d = prv_rd;
      cll_pkg::OP_LINK_W1: begin
        // fresh node links, neighbor captured for the second write
        link_d = link_rd;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (is_after) begin
          prv_wdata = anchor;
          nxt_wdata = link_rd;
        end else begin
          nxt_wdata = anchor;
          prv_wdata = link_rd;
        end
      end
      cll_pkg::OP_LINK_W2: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (is_after) begin
          prv_waddr = link_q;
          nxt_waddr = anchor;
        end else begin
          nxt_waddr = link_q;
          prv_waddr = anchor;
        end
        if (count_q < CW'(NODE_COUNT)) begin
          count_d = count_q + CW'(1);
        end
        if (cmd_q == cll_pkg::CMD_PUSH_FRONT) begin
          cursor_d = fresh_q;
        end
        finish = 1'b1;
      end
      cll_pkg::OP_UNLINK: begin
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        nxt_waddr = prv_rd;
        nxt_wdata = nxt_rd;
        prv_waddr = nxt_rd;
        prv_wdata = prv_rd;
        if (cursor_q == victim_q) begin
          cursor_d = nxt_rd;
        end
        count_d = count_q - CW'(1);
        finish  = 1'b1;
        if (cmd_q != cll_pkg::CMD_REMOVE) begin
          pvalid = 1'b1;
          popped = victim_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d             = res_q;
    res_d.pad         = '0;
    res_d.popped_node = cll_pkg::NODE_W'(popped);
    res_d.status      = status;
    res_d.list_size   = cll_pkg::SIZE_W'(count_d);
    res_d.list_empty  = (count_d == '0);
    res_d.cursor_node = (count_d == '0) ? '0 : cll_pkg::NODE_W'(cursor_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= cll_pkg::CMD_CLEAR;
      cursor_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        cmd_q <= in_user_i;
      end
      cursor_q <= cursor_d;
      count_q  <= count_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pos_q   <= mod_tbl[in_word.position_node];
      fresh_q <= mod_tbl[in_word.new_node];
    end
    victim_q <= victim_d;
    link_q   <= link_d;
    if (finish) begin
      res_q    <= res_d;
      pvalid_q <= pvalid;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.count_one = (count_q == CW'(1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;
  assign out_user_o  = pvalid_q;

endmodule

`default_nettype wire

[src/cll_ctrl.sv]
// controller: sequences link reads and writes for each command word
`default_nettype none

module cll_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire cll_pkg::stat_t stat_i,
  output cll_pkg::ctl_t       ctl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_VICTIM = 3'd2;
  localparam logic [2:0] S_LINK1  = 3'd3;
  localparam logic [2:0] S_LINK2  = 3'd4;
  localparam logic [2:0] S_UNLINK = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    ctl_o.load   = 1'b0;
    ctl_o.rd_sel = cll_pkg::RD_POS;
    ctl_o.op     = cll_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here until the result register can take a word
        if (stat_i.out_free) begin
          state_d  = S_IDLE;
          ctl_o.op = cll_pkg::OP_SIMPLE;
          case (stat_i.cmd) inside
            cll_pkg::CMD_INS_BEFORE, cll_pkg::CMD_INS_AFTER: begin
              if (!stat_i.empty) begin
                ctl_o.op     = cll_pkg::OP_NONE;
                ctl_o.rd_sel = cll_pkg::RD_POS;
                state_d      = S_LINK1;
              end
            end
            cll_pkg::CMD_PUSH_FRONT, cll_pkg::CMD_PUSH_BACK: begin
              if (stat_i.empty) begin
                ctl_o.op = cll_pkg::OP_SELF;
              end else begin
                ctl_o.op     = cll_pkg::OP_NONE;
                ctl_o.rd_sel = cll_pkg::RD_CURSOR;
                state_d      = S_LINK1;
              end
            end
            cll_pkg::CMD_REMOVE, cll_pkg::CMD_POP_FRONT: begin
              if (stat_i.count_one) begin
                ctl_o.op = cll_pkg::OP_DROP_LAST;
              end else if (!stat_i.empty) begin
                ctl_o.op     = cll_pkg::OP_SET_VICTIM;
                ctl_o.rd_sel = (stat_i.cmd == cll_pkg::CMD_REMOVE) ?
                               cll_pkg::RD_POS : cll_pkg::RD_CURSOR;
                state_d      = S_UNLINK;
              end
            end
            cll_pkg::CMD_POP_BACK: begin
              if (!stat_i.empty) begin
                ctl_o.op     = cll_pkg::OP_NONE;
                ctl_o.rd_sel = cll_pkg::RD_CURSOR;
                state_d      = S_VICTIM;
              end
            end
            default: ;
          endcase
        end
      end
      S_VICTIM: begin
        // tail node is on the prev read port now
        if (stat_i.count_one) begin
          ctl_o.op = cll_pkg::OP_DROP_LAST;
          state_d  = S_IDLE;
        end else begin
          ctl_o.op     = cll_pkg::OP_TAKE_VICTIM;
          ctl_o.rd_sel = cll_pkg::RD_PREV;
          state_d      = S_UNLINK;
        end
      end
      S_LINK1: begin
        ctl_o.op = cll_pkg::OP_LINK_W1;
        state_d  = S_LINK2;
      end
      S_LINK2: begin
        ctl_o.op = cll_pkg::OP_LINK_W2;
        state_d  = S_IDLE;
      end
      S_UNLINK: begin
        ctl_o.op = cll_pkg::OP_UNLINK;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/circular_linked_list_manager.sv]
// Circular doubly linked list manager over NODE_COUNT node slots. Each input
// word carries one command (clear, insert before/after, push front/back,
// remove, pop front/back, set cursor) and yields exactly one output word with
// the popped node, status, size, empty flag and cursor. Next and previous
// links live in two single-port-write rams with a registered read. Clear,
// set cursor, the empty-list cases, a push onto an empty list and a remove
// or pop front of the last node read no link. Remove and pop front read both
// links of the node, then write its neighbors; insert and push read the
// anchor link, then write the new node's links, then its neighbors' links;
// pop back reads the tail, then its links, and a pop back that takes the
// last node drops it once the tail is read. One word is worked on at a time;
// a finished result waits in the output register while the next word is
// taken, and the next word is held in its first state until that register
// is free. Node indices are reduced modulo NODE_COUNT. Link entries are not
// cleared at reset.
`default_nettype none

module circular_linked_list_manager #(
  parameter int unsigned NODE_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // position_node, new_node
  input  wire logic [3:0]  s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // popped_node, status, list_size, list_empty,
                                          // cursor_node, zero pad
  output logic             m_axis_tuser   // popped_valid
);

  cll_pkg::ctl_t  ctl;
  cll_pkg::stat_t stat;

  cll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  cll_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

[src/cll_checker.sv]
// port-level checks of the circular linked list manager and their binding
`default_nettype none

module cll_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  cll_pkg::res_t res;
  assign res = cll_pkg::res_t'(m_axis_tdata);

  // one word in flight: no back-to-back acceptance
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.list_empty |-> res.cursor_node == '0)
    else $error("cursor shown on an empty list");

  a_popped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser ? (res.status == cll_pkg::ST_OK)
                                    : (res.popped_node == '0)))
    else $error("popped node and status disagree");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.status == cll_pkg::ST_OK ||
                      res.status == cll_pkg::ST_POP_EMPTY ||
                      res.status == cll_pkg::ST_INVALID)
    else $error("undefined status code");

endmodule

bind circular_linked_list_manager cll_checker u_cll_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[sim/cll_list_checker.sv]
`timescale 1ns / 1ps
// result checker: predicts each command's outcome and compares the output words
module cll_list_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // position_node, new_node
  input  logic [3:0]  s_axis_tuser_i,   // command
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // popped_node, status, list_size, list_empty,
                                        // cursor_node, zero pad
  input  logic        m_axis_tuser_i,   // popped_valid
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);

  localparam int unsigned NODE_COUNT = 256;

  typedef struct packed {
    logic [cll_pkg::NODE_W-1:0]   popped;
    logic                         pvalid;
    logic [cll_pkg::STATUS_W-1:0] status;
    logic [cll_pkg::SIZE_W-1:0]   total;
    logic                         empty;
    logic [cll_pkg::NODE_W-1:0]   cursor;
  } outcome_t;

  logic [cll_pkg::NODE_W-1:0] next_of [NODE_COUNT];
  logic [cll_pkg::NODE_W-1:0] prev_of [NODE_COUNT];
  logic [cll_pkg::NODE_W-1:0] front = '0;
  logic [cll_pkg::SIZE_W-1:0] node_total = '0;

  outcome_t expected_results[$];
  int errors = 0;
  int pending = 0;
  int results_seen = 0;

  assign errors_o  = errors;
  assign pending_o = pending;
  assign results_o = results_seen;

  task automatic count_up();
    if (node_total < NODE_COUNT) node_total++;
  endtask

  task automatic splice_before(input logic [cll_pkg::NODE_W-1:0] anchor,
                               input logic [cll_pkg::NODE_W-1:0] fresh);
    logic [cll_pkg::NODE_W-1:0] p;
    p = prev_of[anchor];
    next_of[fresh]  = anchor;
    prev_of[fresh]  = p;
    next_of[p]      = fresh;
    prev_of[anchor] = fresh;
    count_up();
  endtask

  task automatic push_node(input logic [cll_pkg::NODE_W-1:0] fresh, input logic to_front);
    if (node_total == 0) begin
      // first node links to itself
      next_of[fresh] = fresh;
      prev_of[fresh] = fresh;
      front          = fresh;
      node_total     = 1;
    end else begin
      splice_before(front, fresh);
      if (to_front) front = fresh;
    end
  endtask

  task automatic unlink_node(input logic [cll_pkg::NODE_W-1:0] victim);
    logic [cll_pkg::NODE_W-1:0] p;
    logic [cll_pkg::NODE_W-1:0] n;
    if (node_total == 1) begin
      front = '0;
    end else begin
      p = prev_of[victim];
      n = next_of[victim];
      next_of[p] = n;
      prev_of[n] = p;
      if (front == victim) front = n;
    end
    node_total--;
  endtask

  task automatic predict_command(input logic [cll_pkg::CMD_W-1:0] cmd,
                                 input cll_pkg::in_t word, output outcome_t o);
    logic was_empty;
    logic [cll_pkg::NODE_W-1:0] n;
    o = '0;
    was_empty = (node_total == 0);
    case (cmd)
      cll_pkg::CMD_CLEAR: begin
        node_total = '0;
        front      = '0;
      end
      cll_pkg::CMD_INS_BEFORE: begin
        if (was_empty) o.status = cll_pkg::ST_INVALID;
        else splice_before(word.position_node, word.new_node);
      end
      cll_pkg::CMD_INS_AFTER: begin
        if (was_empty) begin
          o.status = cll_pkg::ST_INVALID;
        end else begin
          n = next_of[word.position_node];
          prev_of[word.new_node]      = word.position_node;
          next_of[word.new_node]      = n;
          prev_of[n]                  = word.new_node;
          next_of[word.position_node] = word.new_node;
          count_up();
        end
      end
      cll_pkg::CMD_PUSH_FRONT: push_node(word.new_node, 1'b1);
      cll_pkg::CMD_PUSH_BACK:  push_node(word.new_node, 1'b0);
      cll_pkg::CMD_REMOVE: begin
        if (was_empty) o.status = cll_pkg::ST_INVALID;
        else unlink_node(word.position_node);
      end
      cll_pkg::CMD_POP_FRONT, cll_pkg::CMD_POP_BACK: begin
        if (was_empty) begin
          o.status = cll_pkg::ST_POP_EMPTY;
        end else begin
          o.popped = (cmd == cll_pkg::CMD_POP_FRONT) ? front : prev_of[front];
          o.pvalid = 1'b1;
          unlink_node(o.popped);
        end
      end
      cll_pkg::CMD_SET_CURSOR: front = word.position_node;
      default: ;
    endcase
    o.total  = node_total;
    o.empty  = (node_total == 0);
    o.cursor = o.empty ? '0 : front;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, seen);
    end
  endtask

  always @(posedge clk_i) begin
    cll_pkg::res_t got;
    outcome_t want;
    if (rst_ni) begin
      // outputs first: a word accepted now cannot have its result in the same cycle
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: word %h arrived with nothing pending", results_seen,
                     m_axis_tdata_i);
        end else begin
          want = expected_results.pop_front();
          check_field("popped_node", want.popped, got.popped_node);
          check_field("popped_valid", want.pvalid, m_axis_tuser_i);
          check_field("status", want.status, got.status);
          check_field("list_size", want.total, got.list_size);
          check_field("list_empty", want.empty, got.list_empty);
          check_field("cursor_node", want.cursor, got.cursor_node);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_command(s_axis_tuser_i, s_axis_tdata_i, want);
        expected_results.push_back(want);
      end
      pending = expected_results.size();
    end
  end

endmodule

[sim/circular_linked_list_manager_tb.sv]
`timescale 1ns / 1ps
// testbench top: command stimulus, handshake pacing and verdict for the list manager
module circular_linked_list_manager_tb;

  localparam int unsigned WORD_TARGET = 1650;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [cll_pkg::CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [cll_pkg::CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // position_node, new_node
  logic [3:0]  s_axis_tuser;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // popped_node, status, list_size, list_empty, cursor_node, pad
  logic        m_axis_tuser;   // popped_valid

  int errors;
  int pending;
  int results_seen;
  int unsigned words_sent;
  int unsigned cycle_count;
  int unsigned sink_hold;
  logic no_idle;

  // shadow of a well-formed list, head is the cursor
  logic [cll_pkg::NODE_W-1:0] members[$];
  logic [255:0]               in_list;

  circular_linked_list_manager #(.NODE_COUNT(256)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  cll_list_checker i_list_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results_seen)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [cll_pkg::NODE_W-1:0] rand_node();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [cll_pkg::NODE_W-1:0] free_node();
    logic [cll_pkg::NODE_W-1:0] n;
    n = rand_node();
    while (in_list[n]) n = rand_node();
    return n;
  endfunction

  task automatic send_word(input logic [cll_pkg::CMD_W-1:0] cmd,
                           input logic [cll_pkg::NODE_W-1:0] pos,
                           input logic [cll_pkg::NODE_W-1:0] fresh);
    int unsigned idle;
    idle = no_idle ? 0 : pause_len();
    @(negedge clk_i);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {fresh, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // one well-formed command on the shadow list, random content
  task automatic list_step();
    int unsigned pick;
    int unsigned at;
    logic [cll_pkg::CMD_W-1:0]  cmd;
    logic [cll_pkg::NODE_W-1:0] fresh;
    logic [cll_pkg::NODE_W-1:0] anchor;
    fresh = free_node();
    pick  = $urandom_range(0, 99);
    if (members.size() == 0) begin
      if (pick < 12) begin
        // commands that must leave an empty list alone
        case (pick % 6)
          0: cmd = cll_pkg::CMD_INS_BEFORE;
          1: cmd = cll_pkg::CMD_INS_AFTER;
          2: cmd = cll_pkg::CMD_REMOVE;
          3: cmd = cll_pkg::CMD_POP_FRONT;
          4: cmd = cll_pkg::CMD_POP_BACK;
          default: cmd = cll_pkg::CMD_SET_CURSOR;
        endcase
        send_word(cmd, rand_node(), rand_node());
      end else begin
        send_word(pick[0] ? cll_pkg::CMD_PUSH_FRONT : cll_pkg::CMD_PUSH_BACK, rand_node(),
                  fresh);
        members.push_back(fresh);
        in_list[fresh] = 1'b1;
      end
    end else begin
      at     = $urandom_range(0, members.size() - 1);
      anchor = members[at];
      if (pick < 15) begin
        send_word(cll_pkg::CMD_INS_BEFORE, anchor, fresh);
        // before the cursor means at the tail of the ring
        if (at == 0) members.push_back(fresh);
        else members.insert(at, fresh);
        in_list[fresh] = 1'b1;
      end else if (pick < 30) begin
        send_word(cll_pkg::CMD_INS_AFTER, anchor, fresh);
        if (at == members.size() - 1) members.push_back(fresh);
        else members.insert(at + 1, fresh);
        in_list[fresh] = 1'b1;
      end else if (pick < 42) begin
        send_word(cll_pkg::CMD_PUSH_FRONT, rand_node(), fresh);
        members.push_front(fresh);
        in_list[fresh] = 1'b1;
      end else if (pick < 54) begin
        send_word(cll_pkg::CMD_PUSH_BACK, rand_node(), fresh);
        members.push_back(fresh);
        in_list[fresh] = 1'b1;
      end else if (pick < 66) begin
        send_word(cll_pkg::CMD_REMOVE, anchor, rand_node());
        members.delete(at);
        in_list[anchor] = 1'b0;
      end else if (pick < 77) begin
        send_word(cll_pkg::CMD_POP_FRONT, rand_node(), rand_node());
        in_list[members.pop_front()] = 1'b0;
      end else if (pick < 88) begin
        send_word(cll_pkg::CMD_POP_BACK, rand_node(), rand_node());
        in_list[members.pop_back()] = 1'b0;
      end else begin
        send_word(cll_pkg::CMD_SET_CURSOR, anchor, rand_node());
        repeat (at) members.push_back(members.pop_front());
      end
    end
  endtask

  task automatic run_episode(input int unsigned ops);
    logic [cll_pkg::NODE_W-1:0] fresh;
    no_idle = ($urandom_range(0, 4) == 0);
    send_word(cll_pkg::CMD_CLEAR, rand_node(), rand_node());
    members.delete();
    in_list = '0;
    repeat (ops) list_step();
    // trailing noise: any code, often reusing live nodes
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        if (members.size() > 0 && $urandom_range(0, 1) == 1)
          fresh = members[$urandom_range(0, members.size() - 1)];
        else
          fresh = rand_node();
        send_word(4'($urandom_range(0, 15)), rand_node(), fresh);
      end
    end
  endtask

  // result side: random stalls, some of them long
  initial begin
    m_axis_tready = 1'b0;
    sink_hold     = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) sink_hold = pause_len();
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL circular_linked_list_manager");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    no_idle       = 1'b0;
    words_sent    = 0;
    in_list       = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list corner cases and unused codes
    send_word(cll_pkg::CMD_POP_FRONT, 8'h00, 8'hFF);
    send_word(cll_pkg::CMD_POP_BACK, 8'hFF, 8'h00);
    send_word(cll_pkg::CMD_INS_BEFORE, 8'h00, 8'hFF);
    send_word(cll_pkg::CMD_INS_AFTER, 8'hFF, 8'h00);
    send_word(cll_pkg::CMD_REMOVE, 8'hFF, 8'hFF);
    send_word(cll_pkg::CMD_SET_CURSOR, 8'hAA, 8'h55);
    send_word(CMD_UNUSED_LO, 8'h12, 8'h34);
    send_word(CMD_UNUSED_HI, 8'hFF, 8'hFF);
    // build 55,0F,00,FF,AA then take it apart
    send_word(cll_pkg::CMD_PUSH_FRONT, 8'hFF, 8'h00);
    send_word(cll_pkg::CMD_PUSH_BACK, 8'h00, 8'hFF);
    send_word(cll_pkg::CMD_PUSH_FRONT, 8'h00, 8'h55);
    send_word(cll_pkg::CMD_INS_AFTER, 8'hFF, 8'hAA);
    send_word(cll_pkg::CMD_INS_BEFORE, 8'h00, 8'h0F);
    send_word(cll_pkg::CMD_SET_CURSOR, 8'hAA, 8'h00);
    send_word(cll_pkg::CMD_POP_BACK, 8'h00, 8'h00);
    send_word(cll_pkg::CMD_POP_FRONT, 8'hFF, 8'hFF);
    send_word(cll_pkg::CMD_REMOVE, 8'h00, 8'hFF);
    send_word(cll_pkg::CMD_REMOVE, 8'h55, 8'h00);   // cursor node
    send_word(cll_pkg::CMD_POP_BACK, 8'h00, 8'h00); // last node
    send_word(cll_pkg::CMD_PUSH_BACK, 8'h00, 8'h80);
    send_word(cll_pkg::CMD_REMOVE, 8'h80, 8'h00);
    send_word(cll_pkg::CMD_PUSH_FRONT, 8'h00, 8'h01);
    send_word(cll_pkg::CMD_PUSH_BACK, 8'h00, 8'h02);
    send_word(cll_pkg::CMD_CLEAR, 8'hFF, 8'hFF);

    // fill the whole table so every link entry holds a value, then saturate
    for (int n = 0; n < 256; n++) send_word(cll_pkg::CMD_PUSH_BACK, rand_node(), 8'(n));
    repeat (4) send_word(cll_pkg::CMD_PUSH_BACK, rand_node(), rand_node());
    send_word(cll_pkg::CMD_POP_FRONT, rand_node(), rand_node());
    send_word(cll_pkg::CMD_REMOVE, 8'h80, rand_node());

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 9) == 0) run_episode($urandom_range(100, 200));
      else run_episode($urandom_range(4, 40));
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d command words: empty-list cases, full-table fill and saturation,",
             words_sent);
    $display("random list episodes with noise; %0d result words compared", results_seen);
    if (errors == 0) begin
      $display("PASS circular_linked_list_manager");
    end else begin
      $display("FAIL circular_linked_list_manager");
    end
    $finish;
  end

endmodule
